// File: hdl/dldf_pkg.sv
// Shared constants and types of the delimiter and length deframer.
`default_nettype none
package dldf_pkg;
   localparam int MAX_SEP_BYTES_DEF = 8;
   localparam int COUNT_BITS_DEF = 16;

   localparam logic [2:0] REG_DECODE_MODE = 3'd0;
   localparam logic [2:0] REG_FRAME_LENGTH = 3'd1;
   localparam logic [2:0] REG_SEP_PATTERN = 3'd2;
   localparam logic [2:0] REG_SEP_LENGTH = 3'd3;
   localparam logic [2:0] REG_MAX_CHUNK = 3'd4;

   typedef struct packed {
      logic [7:0] out_byte;
      logic has_data;
      logic frame_end;
      logic truncated;
   } result_type;
endpackage
`default_nettype wire

// File: hdl/delimiter_length_deframer_unit.sv
// Top level of the delimiter and length deframer.
// The block takes one stream byte per transfer on the req_ channel and gives
// frame results on the rsp_ channel. In length mode every byte gives one
// result; in separator mode a byte gives up to eight results, or none while
// it may be part of the separator. Configuration is written on the csr_
// channel, which is always ready. The user must write it only while the
// block is idle; the block does not enforce this. An accepted byte is
// evaluated in the next cycle. A separator mode byte that mismatches then
// passes a release step for each held separator byte that it releases and
// is checked again against the first separator byte. The shared release
// step, which counts the chunk and moves the held byte out, handles one
// byte per cycle while the receiver does not stall. Results leave through
// a single output register, so a result reaches rsp_valid in the cycle
// after it is made. When the receiver stalls, the step that needs the output
// register waits, and req_stall stays high until the byte is done.
// Reset restores the register defaults and empties all frame state.
`default_nettype none
module delimiter_length_deframer_unit #(
   parameter int MAX_SEP_BYTES = dldf_pkg::MAX_SEP_BYTES_DEF,
   parameter int COUNT_BITS = dldf_pkg::COUNT_BITS_DEF
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_stall,
   input wire logic [7:0] req_in_byte,
   output logic rsp_valid,
   input wire logic rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic rsp_has_data,
   output logic rsp_frame_end,
   output logic rsp_truncated,
   input wire logic csr_valid,
   output logic csr_ready,
   input wire logic [2:0] csr_index,
   input wire logic [63:0] csr_wdata
);
   localparam int LW = (COUNT_BITS > 16) ? COUNT_BITS : 16;
   localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};
   localparam logic [LW-1:0] CMAX_W = LW'(CMAX);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EVAL = 2'd1;
   localparam logic [1:0] S_REL = 2'd2;
   localparam logic [1:0] S_TAIL = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [7:0] byte_ff, byte_in;
   logic [3:0] match_ff, match_in;
   logic [COUNT_BITS-1:0] chunk_ff, chunk_in;
   logic held_valid_ff, held_valid_in;
   logic [7:0] held_byte_ff, held_byte_in;
   logic [2:0] rel_idx_ff, rel_idx_in;
   logic [2:0] rel_end_ff, rel_end_in;

   logic mode_ff, mode_in;
   logic [15:0] frame_len_ff, frame_len_in;
   logic [63:0] pattern_ff, pattern_in;
   logic [3:0] sep_len_ff, sep_len_in;
   logic [15:0] max_chunk_ff, max_chunk_in;

   logic [LW-1:0] frame_w, max_w;
   logic [COUNT_BITS-1:0] frame_lim, max_lim;
   logic [3:0] eff_len;
   logic [3:0] m_eff;
   logic [2:0] sel_idx;
   logic [7:0] sel_byte;
   logic sel_hit;
   logic [7:0] rel_byte;
   logic [COUNT_BITS-1:0] chunk_sat, rel_base;
   logic do_len, do_rel, do_close;
   logic out_free;
   logic emit;
   dldf_pkg::result_type result;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      frame_w = (frame_len_ff == 16'd0) ? LW'(1) : LW'(frame_len_ff);
      max_w = (max_chunk_ff == 16'd0) ? LW'(1) : LW'(max_chunk_ff);
      frame_lim = (frame_w > CMAX_W) ? CMAX : frame_w[COUNT_BITS-1:0];
      max_lim = (max_w > CMAX_W) ? CMAX : max_w[COUNT_BITS-1:0];
      if (sep_len_ff == 4'd0) begin
         eff_len = 4'd1;
      end else if (sep_len_ff > 4'(MAX_SEP_BYTES)) begin
         eff_len = 4'(MAX_SEP_BYTES);
      end else begin
         eff_len = sep_len_ff;
      end
      m_eff = (match_ff >= eff_len) ? 4'd0 : match_ff;
   end

   always_comb begin
      case (state_ff)
         S_EVAL: sel_idx = m_eff[2:0];
         S_REL: sel_idx = rel_idx_ff;
         default: sel_idx = 3'd0;
      endcase
      sel_byte = pattern_ff[{sel_idx, 3'b000} +: 8];
      sel_hit = (byte_ff == sel_byte);
      rel_byte = (state_ff == S_REL) ? sel_byte : byte_ff;
   end

   always_comb begin
      state_in = state_ff;
      byte_in = byte_ff;
      match_in = match_ff;
      rel_idx_in = rel_idx_ff;
      rel_end_in = rel_end_ff;
      do_len = 1'b0;
      do_rel = 1'b0;
      do_close = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               byte_in = req_in_byte;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (!mode_ff) begin
               if (out_free) begin
                  do_len = 1'b1;
                  state_in = S_IDLE;
               end
            end else if (sel_hit) begin
               if (m_eff + 4'd1 == eff_len) begin
                  if (out_free) begin
                     do_close = 1'b1;
                     match_in = 4'd0;
                     state_in = S_IDLE;
                  end
               end else begin
                  match_in = m_eff + 4'd1;
                  state_in = S_IDLE;
               end
            end else if (m_eff == 4'd0) begin
               state_in = S_TAIL;
            end else begin
               rel_idx_in = 3'd0;
               rel_end_in = 3'(m_eff - 4'd1);
               state_in = S_REL;
            end
         end
         S_REL: begin
            if (!held_valid_ff || out_free) begin
               do_rel = 1'b1;
               rel_idx_in = rel_idx_ff + 3'd1;
               if (rel_idx_ff == rel_end_ff) begin
                  state_in = S_TAIL;
               end
            end
         end
         S_TAIL: begin
            if (sel_hit) begin
               if (eff_len == 4'd1) begin
                  if (out_free) begin
                     do_close = 1'b1;
                     match_in = 4'd0;
                     state_in = S_IDLE;
                  end
               end else begin
                  match_in = 4'd1;
                  state_in = S_IDLE;
               end
            end else if (!held_valid_ff || out_free) begin
               do_rel = 1'b1;
               match_in = 4'd0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      chunk_in = chunk_ff;
      held_valid_in = held_valid_ff;
      held_byte_in = held_byte_ff;
      emit = 1'b0;
      result = '0;
      chunk_sat = (chunk_ff == CMAX) ? chunk_ff : chunk_ff + 1'b1;
      rel_base = chunk_ff;
      if (do_len) begin
         emit = 1'b1;
         result.out_byte = byte_ff;
         result.has_data = 1'b1;
         if (chunk_sat >= frame_lim) begin
            result.frame_end = 1'b1;
            chunk_in = '0;
         end else begin
            chunk_in = chunk_sat;
         end
      end
      if (do_rel) begin
         if (held_valid_ff) begin
            emit = 1'b1;
            result.out_byte = held_byte_ff;
            result.has_data = 1'b1;
            if (chunk_ff >= max_lim) begin
               result.frame_end = 1'b1;
               result.truncated = 1'b1;
               rel_base = '0;
            end
         end
         held_byte_in = rel_byte;
         held_valid_in = 1'b1;
         chunk_in = (rel_base == CMAX) ? rel_base : rel_base + 1'b1;
      end
      if (do_close) begin
         emit = 1'b1;
         result.out_byte = held_valid_ff ? held_byte_ff : 8'd0;
         result.has_data = held_valid_ff;
         result.frame_end = 1'b1;
         chunk_in = '0;
         held_valid_in = 1'b0;
         held_byte_in = 8'd0;
      end
   end

   always_comb begin
      mode_in = mode_ff;
      frame_len_in = frame_len_ff;
      pattern_in = pattern_ff;
      sep_len_in = sep_len_ff;
      max_chunk_in = max_chunk_ff;
      if (csr_valid) begin
         case (csr_index)
            dldf_pkg::REG_DECODE_MODE: mode_in = csr_wdata[0];
            dldf_pkg::REG_FRAME_LENGTH: frame_len_in = csr_wdata[15:0];
            dldf_pkg::REG_SEP_PATTERN: pattern_in = csr_wdata;
            dldf_pkg::REG_SEP_LENGTH: sep_len_in = csr_wdata[3:0];
            dldf_pkg::REG_MAX_CHUNK: max_chunk_in = csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   logic cfg_clear;
   assign cfg_clear = csr_valid && ((csr_index == dldf_pkg::REG_DECODE_MODE) ||
      (csr_index == dldf_pkg::REG_SEP_PATTERN) || (csr_index == dldf_pkg::REG_SEP_LENGTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         match_ff <= 4'd0;
         chunk_ff <= '0;
         held_valid_ff <= 1'b0;
         held_byte_ff <= 8'd0;
         mode_ff <= 1'b0;
         frame_len_ff <= 16'd1;
         pattern_ff <= 64'd10;
         sep_len_ff <= 4'd1;
         max_chunk_ff <= 16'hFFFF;
      end else begin
         state_ff <= state_in;
         mode_ff <= mode_in;
         frame_len_ff <= frame_len_in;
         pattern_ff <= pattern_in;
         sep_len_ff <= sep_len_in;
         max_chunk_ff <= max_chunk_in;
         if (cfg_clear) begin
            match_ff <= 4'd0;
            chunk_ff <= '0;
            held_valid_ff <= 1'b0;
            held_byte_ff <= 8'd0;
         end else begin
            match_ff <= match_in;
            chunk_ff <= chunk_in;
            held_valid_ff <= held_valid_in;
            held_byte_ff <= held_byte_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      rel_idx_ff <= rel_idx_in;
      rel_end_ff <= rel_end_in;
   end

   dldf_out_reg u_out_reg (
      .clock(clock),
      .reset(reset),
      .load(emit),
      .result(result),
      .out_free(out_free),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_byte(rsp_out_byte),
      .rsp_has_data(rsp_has_data),
      .rsp_frame_end(rsp_frame_end),
      .rsp_truncated(rsp_truncated)
   );
endmodule
`default_nettype wire

// File: hdl/dldf_out_reg.sv
// Result register that holds one result until the receiver takes it.
`default_nettype none
module dldf_out_reg (
   input wire logic clock,
   input wire logic reset,
   input wire logic load,
   input wire dldf_pkg::result_type result,
   output logic out_free,
   output logic rsp_valid,
   input wire logic rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic rsp_has_data,
   output logic rsp_frame_end,
   output logic rsp_truncated
);
   logic valid_ff;
   logic valid_in;
   dldf_pkg::result_type data_ff;

   assign out_free = !valid_ff || !rsp_stall;
   assign valid_in = load || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_out_byte = data_ff.out_byte;
   assign rsp_has_data = data_ff.has_data;
   assign rsp_frame_end = data_ff.frame_end;
   assign rsp_truncated = data_ff.truncated;
endmodule
`default_nettype wire
